### rtl/core/mlfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfc_pkg: shared types and constants of the motor link frame codec
// Link byte codes, frame layout, parser phases and controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package mlfc_pkg;

  // Info bytes in one telemetry frame
  localparam int INFO_BYTES = 15;

  // Telemetry fields and stored info entries
  localparam int TLM_FIELDS = 15;
  localparam int TLM_IDX_W  = 4;
  localparam int CNT_W      = ($clog2(INFO_BYTES + 1) > TLM_IDX_W) ?
                              $clog2(INFO_BYTES + 1) : TLM_IDX_W;

  // Command frame layout
  localparam int FRAME_LEN = 8;
  localparam int FRAME_W   = 3;
  localparam logic [7:0] FRAME_RESET [FRAME_LEN] =
    '{8'd1, 8'd255, 8'd8, 8'd51, 8'd0, 8'd0, 8'd0, 8'd4};

  // Item kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // Control types
  localparam logic [1:0] CT_DIFF   = 2'd0;
  localparam logic [1:0] CT_DRIVE  = 2'd1;
  localparam logic [1:0] CT_SINGLE = 2'd2;
  localparam logic [1:0] CT_RSVD   = 2'd3;

  // Result kinds
  localparam logic [1:0] OK_FRAME = 2'd0;
  localparam logic [1:0] OK_TLM   = 2'd1;
  localparam logic [1:0] OK_ERR   = 2'd2;

  // Link byte values
  localparam logic [7:0] START_BYTE = 8'd1;
  localparam logic [7:0] ADDR_BYTE  = 8'd255;
  localparam logic [7:0] STOP_BYTE  = 8'd4;
  localparam logic [7:0] LEN_SHORT  = 8'd7;
  localparam logic [7:0] LEN_LONG   = 8'd8;
  localparam logic [7:0] LEN_TLM    = 8'(INFO_BYTES + 5);
  localparam logic [7:0] PAD_BYTE   = 8'd0;

  // Frame codes
  localparam logic [7:0] CODE_DRIVE   = 8'd51;
  localparam logic [7:0] CODE_DIFF    = 8'd52;
  localparam logic [7:0] CODE_DIFF_RN = 8'd53;
  localparam logic [7:0] CODE_DIFF_LN = 8'd54;
  localparam logic [7:0] CODE_DIFF_BN = 8'd55;
  localparam logic [7:0] MOTOR_OFS    = 8'd9;

  // Direction codes
  localparam logic [7:0] DIR_STOP    = 8'd0;
  localparam logic [7:0] DIR_FWD_NEG = 8'd1;
  localparam logic [7:0] DIR_FWD_POS = 8'd2;
  localparam logic [7:0] DIR_REV_POS = 8'd3;
  localparam logic [7:0] DIR_REV_NEG = 8'd4;
  localparam logic [7:0] SGL_FWD     = 8'd2;
  localparam logic [7:0] SGL_REV     = 8'd1;

  // Speed setpoint below which telemetry speeds read zero
  localparam logic [7:0] SPEED_MIN = 8'd20;

  // Parser phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_INFO = 3'd4;
  localparam logic [2:0] PH_END  = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic       latch;     // capture input word
    logic       exec_cmd;  // rebuild command frame
    logic       exec_byte; // advance parser
    logic       clr_idx;   // restart result index
    logic       load_out;  // load output register
    logic [1:0] out_sel;   // result kind being emitted
  } mlfc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_cmd;    // latched word is a motor command
    logic ct_ok;     // control type builds a frame
    logic end_byte;  // parser sits at the end byte
    logic end_pass;  // end byte and length check pass
    logic last_pos;  // current index is the final result
  } mlfc_sts_t;

  // Magnitude clipped to one byte
  function automatic logic [7:0] mag8(input logic [8:0] v);
    logic [8:0] a;
    a = v[8] ? (~v + 9'd1) : v;
    return a[8] ? 8'hFF : a[7:0];
  endfunction

  // Speed correction: zero below setpoint, optional negate
  function automatic logic [8:0] corr(input logic [7:0] raw, input logic zero,
                                      input logic neg);
    logic [8:0] m;
    m = zero ? 9'd0 : {1'b0, raw};
    return neg ? (~m + 9'd1) : m;
  endfunction

endpackage
`default_nettype wire

### rtl/core/motor_link_frame_codec_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_link_frame_codec_top: motor link frame codec
// Builds motor command frames and parses telemetry frames from the link.
//
//   channel  direction  handshake            payload
//   in_*     input      in_valid/in_ready    kind, control type, speeds, byte
//   out_*    output     out_valid/out_ready  kind, field index, value, last
//
// A word is processed in the cycle after it is taken. Results then leave
// one per cycle through the output register: 7 or 8 frame bytes per
// command of a non-reserved control type, 15 telemetry fields or one
// error word at the end of a received frame. Back pressure on out_ready
// stalls the result run; the next input word is taken once the last result
// of a run sits in the output register. Reset gives the default drive frame
// and a parser hunting for a start byte; the info store is not cleared.
// ----------------------------------------------------------------------------
module motor_link_frame_codec_top (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              in_kind,
  input  wire [1:0]        in_control_type,
  input  wire signed [8:0] in_left_speed,
  input  wire signed [8:0] in_right_speed,
  input  wire signed [8:0] in_drive_speed,
  input  wire signed [8:0] in_steer_angle,
  input  wire [3:0]        in_motor_select,
  input  wire signed [8:0] in_motor_drive,
  input  wire [7:0]        in_rx_byte,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_field_index,
  output logic signed [8:0] out_field_value,
  output logic             out_last
);

  mlfc_pkg::mlfc_cmd_t cmd;
  mlfc_pkg::mlfc_sts_t sts;

  // sequencing
  mlfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // frame build, parse and result formatting
  mlfc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_control_type (in_control_type),
    .in_left_speed   (in_left_speed),
    .in_right_speed  (in_right_speed),
    .in_drive_speed  (in_drive_speed),
    .in_steer_angle  (in_steer_angle),
    .in_motor_select (in_motor_select),
    .in_motor_drive  (in_motor_drive),
    .in_rx_byte      (in_rx_byte),
    .out_kind        (out_kind),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

### rtl/core/mlfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfc_ctrl: sequencing controller
// Takes one word at a time, runs it through the step state and then paces the results
// into the output register.
// ----------------------------------------------------------------------------
module mlfc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  mlfc_pkg::mlfc_sts_t sts,
  output mlfc_pkg::mlfc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_FRM  = 3'd2;
  localparam logic [2:0] S_TLM  = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot;

  // output register free or draining this cycle
  assign slot = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        state_nxt = S_IDLE;
        if (sts.is_cmd) begin
          cmd.exec_cmd = 1'b1;
          if (sts.ct_ok) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = S_FRM;
          end
        end else begin
          cmd.exec_byte = 1'b1;
          if (sts.end_byte) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = sts.end_pass ? S_TLM : S_ERR;
          end
        end
      end
      S_FRM, S_TLM, S_ERR: begin
        cmd.out_sel  = (state_r == S_FRM) ? mlfc_pkg::OK_FRAME :
                       (state_r == S_TLM) ? mlfc_pkg::OK_TLM : mlfc_pkg::OK_ERR;
        cmd.load_out = slot;
        if (slot && sts.last_pos) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // step state always moves on to another state
  a_step_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |=> state_r != S_STEP)
    else $error("step state held");

  // never overwrite a word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output overwritten");

  // an error run is a single word
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR && cmd.load_out) |=> state_r == S_IDLE)
    else $error("error run too long");

  // valid drops only after the word was taken
  a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("output word lost");

endmodule
`default_nettype wire

### rtl/core/mlfc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfc_dp: codec datapath
// Input capture, command frame builder, link byte parser, info store,
// telemetry correction and the output register.
// ----------------------------------------------------------------------------
module mlfc_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mlfc_pkg::mlfc_cmd_t  cmd,
  output mlfc_pkg::mlfc_sts_t  sts,
  input  wire                  in_kind,
  input  wire [1:0]            in_control_type,
  input  wire signed [8:0]     in_left_speed,
  input  wire signed [8:0]     in_right_speed,
  input  wire signed [8:0]     in_drive_speed,
  input  wire signed [8:0]     in_steer_angle,
  input  wire [3:0]            in_motor_select,
  input  wire signed [8:0]     in_motor_drive,
  input  wire [7:0]            in_rx_byte,
  output logic [1:0]           out_kind,
  output logic [3:0]           out_field_index,
  output logic signed [8:0]    out_field_value,
  output logic                 out_last
);

  // captured input word
  logic       kind_r;
  logic [1:0] ct_r;
  logic [8:0] left_r, right_r, dspd_r, ang_r, mdrv_r;
  logic [3:0] msel_r;
  logic [7:0] byte_r;

  // command frame and parser state
  logic [7:0] frame_r   [mlfc_pkg::FRAME_LEN];
  logic [7:0] frame_nxt [mlfc_pkg::FRAME_LEN];
  logic [2:0] phase_r, phase_nxt;
  logic [mlfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0] len_r;
  logic [7:0] info_r [mlfc_pkg::TLM_FIELDS];

  // result index and output register
  logic [mlfc_pkg::TLM_IDX_W-1:0] idx_r;
  logic [1:0] okind_r;
  logic [3:0] oidx_r;
  logic [8:0] oval_r;
  logic       olast_r;

  logic [7:0] flen;
  logic [3:0] frm_last;
  logic       zero_a, zero_b, neg_a, neg_b;
  logic [8:0] v2, v5, tval, val_nxt;
  logic [9:0] lsum, lhalf;
  logic       last_nxt;
  logic       info_wr;

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      ct_r    <= in_control_type;
      left_r  <= in_left_speed;
      right_r <= in_right_speed;
      dspd_r  <= in_drive_speed;
      ang_r   <= in_steer_angle;
      msel_r  <= in_motor_select;
      mdrv_r  <= in_motor_drive;
      byte_r  <= in_rx_byte;
    end
  end

  // frame builder
  always_comb begin
    frame_nxt    = frame_r;
    frame_nxt[0] = mlfc_pkg::START_BYTE;
    frame_nxt[1] = mlfc_pkg::ADDR_BYTE;
    case (ct_r)
      mlfc_pkg::CT_DIFF: begin
        frame_nxt[2] = mlfc_pkg::LEN_SHORT;
        frame_nxt[3] = mlfc_pkg::CODE_DIFF + {6'd0, left_r[8], right_r[8]};
        frame_nxt[4] = mlfc_pkg::mag8(right_r);
        frame_nxt[5] = mlfc_pkg::mag8(left_r);
        frame_nxt[6] = mlfc_pkg::STOP_BYTE;
        frame_nxt[7] = mlfc_pkg::PAD_BYTE;
      end
      mlfc_pkg::CT_DRIVE: begin
        frame_nxt[2] = mlfc_pkg::LEN_LONG;
        frame_nxt[3] = mlfc_pkg::CODE_DRIVE;
        if (dspd_r == 9'd0)
          frame_nxt[4] = mlfc_pkg::DIR_STOP;
        else if (!dspd_r[8])
          frame_nxt[4] = (!ang_r[8] && ang_r != 9'd0) ?
                         mlfc_pkg::DIR_FWD_POS : mlfc_pkg::DIR_FWD_NEG;
        else
          frame_nxt[4] = (!ang_r[8] && ang_r != 9'd0) ?
                         mlfc_pkg::DIR_REV_POS : mlfc_pkg::DIR_REV_NEG;
        frame_nxt[5] = mlfc_pkg::mag8(dspd_r);
        frame_nxt[6] = mlfc_pkg::mag8(ang_r);
        frame_nxt[7] = mlfc_pkg::STOP_BYTE;
      end
      mlfc_pkg::CT_SINGLE: begin
        frame_nxt[2] = mlfc_pkg::LEN_SHORT;
        frame_nxt[3] = {4'd0, msel_r} + mlfc_pkg::MOTOR_OFS;
        frame_nxt[4] = mlfc_pkg::mag8(mdrv_r);
        if (mdrv_r == 9'd0)  frame_nxt[5] = mlfc_pkg::DIR_STOP;
        else if (mdrv_r[8])  frame_nxt[5] = mlfc_pkg::SGL_REV;
        else                 frame_nxt[5] = mlfc_pkg::SGL_FWD;
        frame_nxt[6] = mlfc_pkg::STOP_BYTE;
        frame_nxt[7] = mlfc_pkg::PAD_BYTE;
      end
      default: frame_nxt = frame_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= mlfc_pkg::FRAME_RESET;
    end else if (cmd.exec_cmd) begin
      frame_r <= frame_nxt;
    end
  end

  // link byte parser
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    info_wr   = 1'b0;
    case (phase_r)
      mlfc_pkg::PH_ADDR:
        phase_nxt = (byte_r == mlfc_pkg::ADDR_BYTE) ? mlfc_pkg::PH_LEN : mlfc_pkg::PH_HUNT;
      mlfc_pkg::PH_LEN:
        phase_nxt = mlfc_pkg::PH_CTRL;
      mlfc_pkg::PH_CTRL: begin
        cnt_nxt   = '0;
        phase_nxt = mlfc_pkg::PH_INFO;
      end
      mlfc_pkg::PH_INFO: begin
        info_wr = (cnt_r < mlfc_pkg::CNT_W'(mlfc_pkg::TLM_FIELDS));
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt >= mlfc_pkg::CNT_W'(mlfc_pkg::INFO_BYTES))
          phase_nxt = mlfc_pkg::PH_END;
      end
      mlfc_pkg::PH_END: begin
        cnt_nxt   = '0;
        phase_nxt = mlfc_pkg::PH_HUNT;
      end
      default:
        phase_nxt = (byte_r == mlfc_pkg::START_BYTE) ? mlfc_pkg::PH_ADDR : mlfc_pkg::PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mlfc_pkg::PH_HUNT;
      cnt_r   <= '0;
      len_r   <= '0;
    end else if (cmd.exec_byte) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (phase_r == mlfc_pkg::PH_LEN) len_r <= byte_r;
    end
  end

  // info store, one write port
  always_ff @(posedge clk) begin
    if (cmd.exec_byte && info_wr)
      info_r[cnt_r[mlfc_pkg::TLM_IDX_W-1:0]] <= byte_r;
  end

  // status to controller
  assign flen     = (frame_r[2] > mlfc_pkg::LEN_LONG) ? mlfc_pkg::LEN_LONG : frame_r[2];
  assign frm_last = flen[3:0] - 4'd1;

  always_comb begin
    sts.is_cmd   = (kind_r == mlfc_pkg::KIND_CMD);
    sts.ct_ok    = (ct_r != mlfc_pkg::CT_RSVD);
    sts.end_byte = (phase_r == mlfc_pkg::PH_END);
    sts.end_pass = (len_r == mlfc_pkg::LEN_TLM) && (byte_r == mlfc_pkg::STOP_BYTE);
    case (cmd.out_sel)
      mlfc_pkg::OK_FRAME: sts.last_pos = (idx_r == frm_last);
      mlfc_pkg::OK_TLM:   sts.last_pos = (idx_r == 4'(mlfc_pkg::TLM_FIELDS - 1));
      default:            sts.last_pos = 1'b1;
    endcase
  end

  // telemetry correction from the stored command frame
  assign zero_a = frame_r[5] < mlfc_pkg::SPEED_MIN;
  assign zero_b = frame_r[4] < mlfc_pkg::SPEED_MIN;
  assign neg_a  = (frame_r[3] == mlfc_pkg::CODE_DIFF_LN) ||
                  (frame_r[3] == mlfc_pkg::CODE_DIFF_BN);
  assign neg_b  = (frame_r[3] == mlfc_pkg::CODE_DIFF_RN) ||
                  (frame_r[3] == mlfc_pkg::CODE_DIFF_BN);
  assign v2     = mlfc_pkg::corr(info_r[2], zero_a, neg_a);
  assign v5     = mlfc_pkg::corr(info_r[5], zero_b, neg_b);
  // linear speed: average, truncated toward zero
  assign lsum   = {v2[8], v2} + {v5[8], v5};
  assign lhalf  = lsum + {9'd0, lsum[9]};

  always_comb begin
    if (idx_r == 4'd0)
      tval = lhalf[9:1];
    else if (idx_r inside {[4'd1:4'd3]})
      tval = mlfc_pkg::corr(info_r[idx_r], zero_a, neg_a);
    else if (idx_r inside {[4'd4:4'd6]})
      tval = mlfc_pkg::corr(info_r[idx_r], zero_b, neg_b);
    else
      tval = {1'b0, info_r[idx_r]};
  end

  // result value select
  always_comb begin
    case (cmd.out_sel)
      mlfc_pkg::OK_FRAME: val_nxt = {1'b0, frame_r[idx_r[mlfc_pkg::FRAME_W-1:0]]};
      mlfc_pkg::OK_TLM:   val_nxt = tval;
      default:            val_nxt = '0;
    endcase
    last_nxt = sts.last_pos;
  end

  // result index counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.clr_idx) begin
      idx_r <= '0;
    end else if (cmd.load_out) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      okind_r <= cmd.out_sel;
      oidx_r  <= (cmd.out_sel == mlfc_pkg::OK_ERR) ? 4'd0 : idx_r;
      oval_r  <= val_nxt;
      olast_r <= last_nxt;
    end
  end

  assign out_kind        = okind_r;
  assign out_field_index = oidx_r;
  assign out_field_value = oval_r;
  assign out_last        = olast_r;

endmodule
`default_nettype wire

### bench/tb_motor_link_frame_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_link_frame_codec_top: self-checking bench of the motor link codec
// Drives motor command words and received link bytes, predicts every frame
// byte, telemetry field and integrity error, and checks each result word in
// order. Directed tests cover the command extremes and parser recovery; the
// random part mixes well-formed and broken frames under several idle mixes.
// ----------------------------------------------------------------------------
module tb_motor_link_frame_codec_top;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 20;
  localparam int FRAME_BYTES = mlfc_pkg::INFO_BYTES + 5;

  // Ways a received frame can be damaged
  typedef enum int {
    FLAW_NONE, FLAW_START, FLAW_ADDR, FLAW_LENGTH, FLAW_STOP, FLAW_SHORT
  } frame_flaw_t;

  // One input word, every field kept
  typedef struct {
    logic              kind;
    logic [1:0]        ctype;
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic signed [8:0] speed;
    logic signed [8:0] angle;
    logic [3:0]        sel;
    logic signed [8:0] drive;
    logic [7:0]        rx;
  } link_word_t;

  // One result word
  typedef struct {
    logic [1:0]        kind;
    logic [3:0]        idx;
    logic signed [8:0] value;
    logic              is_last;
  } link_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [1:0]        in_control_type;
  logic signed [8:0] in_left_speed;
  logic signed [8:0] in_right_speed;
  logic signed [8:0] in_drive_speed;
  logic signed [8:0] in_steer_angle;
  logic [3:0]        in_motor_select;
  logic signed [8:0] in_motor_drive;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_kind;
  logic [3:0]        out_field_index;
  logic signed [8:0] out_field_value;
  logic              out_last;

  // Predicted block state
  logic [7:0] cmd_frame [mlfc_pkg::FRAME_LEN];
  logic [2:0] parse_ph;
  int         info_cnt;
  logic [7:0] len_seen;
  logic [7:0] info_mem [mlfc_pkg::TLM_FIELDS];

  link_result_t expected_results [$];
  link_result_t head_res;

  // Traffic shaping
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_left;

  // Bookkeeping
  int cycle_cnt;
  int fail_cnt;
  int n_words;
  int n_results;
  int n_frame_runs;
  int n_tlm_runs;
  int n_err_runs;

  motor_link_frame_codec_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_control_type (in_control_type),
    .in_left_speed   (in_left_speed),
    .in_right_speed  (in_right_speed),
    .in_drive_speed  (in_drive_speed),
    .in_steer_angle  (in_steer_angle),
    .in_motor_select (in_motor_select),
    .in_motor_drive  (in_motor_drive),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_last        (out_last)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] speed_mag(input logic signed [8:0] v);
    int a;
    a = int'(v);
    if (a < 0) a = -a;
    return (a > 255) ? 8'd255 : a[7:0];
  endfunction

  function automatic void push_result(input logic [1:0] k, input int idx, input int val,
                                      input bit lst);
    link_result_t r;
    r.kind    = k;
    r.idx     = idx[3:0];
    r.value   = val[8:0];
    r.is_last = lst;
    expected_results.push_back(r);
  endfunction

  // Rebuild the stored command frame and emit its first length bytes
  function automatic void build_cmd_frame(input link_word_t w);
    int n;
    if (w.ctype == mlfc_pkg::CT_RSVD) return;
    cmd_frame[0] = mlfc_pkg::START_BYTE;
    cmd_frame[1] = mlfc_pkg::ADDR_BYTE;
    case (w.ctype)
      mlfc_pkg::CT_DIFF: begin
        cmd_frame[2] = mlfc_pkg::LEN_SHORT;
        cmd_frame[3] = mlfc_pkg::CODE_DIFF + {6'd0, w.left < 0, w.right < 0};
        cmd_frame[4] = speed_mag(w.right);
        cmd_frame[5] = speed_mag(w.left);
        cmd_frame[6] = mlfc_pkg::STOP_BYTE;
        cmd_frame[7] = mlfc_pkg::PAD_BYTE;
      end
      mlfc_pkg::CT_DRIVE: begin
        cmd_frame[2] = mlfc_pkg::LEN_LONG;
        cmd_frame[3] = mlfc_pkg::CODE_DRIVE;
        if (w.speed > 0)
          cmd_frame[4] = (w.angle > 0) ? mlfc_pkg::DIR_FWD_POS : mlfc_pkg::DIR_FWD_NEG;
        else if (w.speed == 0)
          cmd_frame[4] = mlfc_pkg::DIR_STOP;
        else
          cmd_frame[4] = (w.angle > 0) ? mlfc_pkg::DIR_REV_POS : mlfc_pkg::DIR_REV_NEG;
        cmd_frame[5] = speed_mag(w.speed);
        cmd_frame[6] = speed_mag(w.angle);
        cmd_frame[7] = mlfc_pkg::STOP_BYTE;
      end
      default: begin
        cmd_frame[2] = mlfc_pkg::LEN_SHORT;
        cmd_frame[3] = {4'd0, w.sel} + mlfc_pkg::MOTOR_OFS;
        cmd_frame[4] = speed_mag(w.drive);
        if (w.drive > 0)
          cmd_frame[5] = mlfc_pkg::SGL_FWD;
        else if (w.drive < 0)
          cmd_frame[5] = mlfc_pkg::SGL_REV;
        else
          cmd_frame[5] = mlfc_pkg::DIR_STOP;
        cmd_frame[6] = mlfc_pkg::STOP_BYTE;
        cmd_frame[7] = mlfc_pkg::PAD_BYTE;
      end
    endcase
    n = int'(cmd_frame[2]);
    for (int i = 0; i < n; i++)
      push_result(mlfc_pkg::OK_FRAME, i, int'(cmd_frame[i]), i == n - 1);
  endfunction

  // Corrected telemetry from the stored info bytes
  function automatic void emit_telemetry();
    int  v [mlfc_pkg::TLM_FIELDS];
    bit  neg_lo;
    bit  neg_hi;
    for (int i = 1; i < mlfc_pkg::TLM_FIELDS; i++) v[i] = int'(info_mem[i]);
    if (cmd_frame[5] < mlfc_pkg::SPEED_MIN) for (int i = 1; i <= 3; i++) v[i] = 0;
    if (cmd_frame[4] < mlfc_pkg::SPEED_MIN) for (int i = 4; i <= 6; i++) v[i] = 0;
    neg_lo = (cmd_frame[3] == mlfc_pkg::CODE_DIFF_LN) ||
             (cmd_frame[3] == mlfc_pkg::CODE_DIFF_BN);
    neg_hi = (cmd_frame[3] == mlfc_pkg::CODE_DIFF_RN) ||
             (cmd_frame[3] == mlfc_pkg::CODE_DIFF_BN);
    if (neg_lo) for (int i = 1; i <= 3; i++) v[i] = -v[i];
    if (neg_hi) for (int i = 4; i <= 6; i++) v[i] = -v[i];
    // linear speed, truncated toward zero
    v[0] = (v[2] + v[5]) / 2;
    for (int i = 0; i < mlfc_pkg::TLM_FIELDS; i++)
      push_result(mlfc_pkg::OK_TLM, i, v[i], i == mlfc_pkg::TLM_FIELDS - 1);
  endfunction

  // Link parser, one received byte
  function automatic void parse_link_byte(input logic [7:0] b);
    case (parse_ph)
      mlfc_pkg::PH_ADDR:
        parse_ph = (b == mlfc_pkg::ADDR_BYTE) ? mlfc_pkg::PH_LEN : mlfc_pkg::PH_HUNT;
      mlfc_pkg::PH_LEN: begin
        len_seen = b;
        parse_ph = mlfc_pkg::PH_CTRL;
      end
      mlfc_pkg::PH_CTRL: begin
        info_cnt = 0;
        parse_ph = mlfc_pkg::PH_INFO;
      end
      mlfc_pkg::PH_INFO: begin
        if (info_cnt < mlfc_pkg::TLM_FIELDS) info_mem[info_cnt] = b;
        info_cnt++;
        if (info_cnt >= mlfc_pkg::INFO_BYTES) parse_ph = mlfc_pkg::PH_END;
      end
      mlfc_pkg::PH_END: begin
        parse_ph = mlfc_pkg::PH_HUNT;
        info_cnt = 0;
        if (len_seen == mlfc_pkg::LEN_TLM && b == mlfc_pkg::STOP_BYTE)
          emit_telemetry();
        else
          push_result(mlfc_pkg::OK_ERR, 0, 0, 1'b1);
      end
      default:
        parse_ph = (b == mlfc_pkg::START_BYTE) ? mlfc_pkg::PH_ADDR : mlfc_pkg::PH_HUNT;
    endcase
  endfunction

  function automatic void predict_word(input link_word_t w);
    if (w.kind == mlfc_pkg::KIND_CMD)
      build_cmd_frame(w);
    else
      parse_link_byte(w.rx);
  endfunction

  // ---------------------------------------------------------------------------
  // Word generation and sending
  // ---------------------------------------------------------------------------
  function automatic link_word_t random_word();
    link_word_t w;
    w.kind  = 1'($urandom_range(1));
    w.ctype = 2'($urandom_range(3));
    w.left  = 9'($urandom_range(511));
    w.right = 9'($urandom_range(511));
    w.speed = 9'($urandom_range(511));
    w.angle = 9'($urandom_range(511));
    w.sel   = 4'($urandom_range(15));
    w.drive = 9'($urandom_range(511));
    w.rx    = 8'($urandom_range(255));
    return w;
  endfunction

  // Speeds lean toward small magnitudes so the setpoint test gets hit
  function automatic logic signed [8:0] rand_speed();
    int s;
    if ($urandom_range(3) == 0) begin
      s = $urandom_range(38) - 19;
      return s[8:0];
    end
    return 9'($urandom_range(511));
  endfunction

  function automatic link_word_t make_cmd(input logic [1:0] ct, input logic signed [8:0] a,
                                          input logic signed [8:0] b, input logic [3:0] sel);
    link_word_t w;
    w       = random_word();
    w.kind  = mlfc_pkg::KIND_CMD;
    w.ctype = ct;
    case (ct)
      mlfc_pkg::CT_DIFF: begin
        w.left  = a;
        w.right = b;
      end
      mlfc_pkg::CT_DRIVE: begin
        w.speed = a;
        w.angle = b;
      end
      mlfc_pkg::CT_SINGLE: begin
        w.drive = a;
        w.sel   = sel;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic link_word_t random_cmd();
    return make_cmd(2'($urandom_range(3)), rand_speed(), rand_speed(),
                    4'($urandom_range(15)));
  endfunction

  // Offer one word, hold it until taken, then record its predicted results
  task automatic send_word(input link_word_t w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= w.kind;
    in_control_type <= w.ctype;
    in_left_speed   <= w.left;
    in_right_speed  <= w.right;
    in_drive_speed  <= w.speed;
    in_steer_angle  <= w.angle;
    in_motor_select <= w.sel;
    in_motor_drive  <= w.drive;
    in_rx_byte      <= w.rx;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
    n_words++;
  endtask

  task automatic send_link_byte(input logic [7:0] b);
    link_word_t w;
    w      = random_word();
    w.kind = mlfc_pkg::KIND_BYTE;
    w.rx   = b;
    send_word(w);
  endtask

  // Send one telemetry frame, optionally damaged, with a command slipped
  // in before byte cmd_at (negative: none)
  task automatic send_frame(input frame_flaw_t flaw, input bit extremes, input int cmd_at,
                            input link_word_t slip);
    logic [7:0] fb [FRAME_BYTES];
    int         cut;
    fb[0] = mlfc_pkg::START_BYTE;
    fb[1] = mlfc_pkg::ADDR_BYTE;
    fb[2] = mlfc_pkg::LEN_TLM;
    fb[3] = 8'($urandom_range(255));
    for (int i = 4; i < FRAME_BYTES - 1; i++)
      fb[i] = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
    fb[FRAME_BYTES - 1] = mlfc_pkg::STOP_BYTE;
    case (flaw)
      FLAW_START: do fb[0] = 8'($urandom_range(255)); while (fb[0] == mlfc_pkg::START_BYTE);
      FLAW_ADDR:  do fb[1] = 8'($urandom_range(255)); while (fb[1] == mlfc_pkg::ADDR_BYTE);
      FLAW_LENGTH: do fb[2] = 8'($urandom_range(255)); while (fb[2] == mlfc_pkg::LEN_TLM);
      FLAW_STOP: begin
        do fb[FRAME_BYTES - 1] = 8'($urandom_range(255));
        while (fb[FRAME_BYTES - 1] == mlfc_pkg::STOP_BYTE);
      end
      default: ;
    endcase
    cut = (flaw == FLAW_SHORT) ? $urandom_range(FRAME_BYTES - 2, 1) : FRAME_BYTES;
    for (int i = 0; i < cut; i++) begin
      if (i == cmd_at) send_word(slip);
      send_link_byte(fb[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus a counted hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic signed [9:0] want,
                             input logic signed [9:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        fail_cnt++;
        $display("%0t: result word with none expected, expected nothing, got %0d/%0d/%0d/%0d",
                 $time, out_kind, out_field_index, out_field_value, out_last);
      end else begin
        head_res = expected_results.pop_front();
        check_field("kind", 10'(head_res.kind), 10'(out_kind));
        check_field("field_index", 10'(head_res.idx), 10'(out_field_index));
        check_field("field_value", 10'(head_res.value), 10'(out_field_value));
        check_field("last", 10'(head_res.is_last), 10'(out_last));
        if (head_res.is_last) begin
          case (head_res.kind)
            mlfc_pkg::OK_FRAME: n_frame_runs++;
            mlfc_pkg::OK_TLM:   n_tlm_runs++;
            default:            n_err_runs++;
          endcase
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still expected", $time,
               expected_results.size());
      $display("tb_motor_link_frame_codec_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every control type, sign combination and magnitude extreme
  task automatic test_command_frames();
    send_word(make_cmd(mlfc_pkg::CT_DIFF, -256, 255, 0));
    send_word(make_cmd(mlfc_pkg::CT_DIFF, 0, -1, 0));
    send_word(make_cmd(mlfc_pkg::CT_DIFF, -255, -20, 0));
    send_word(make_cmd(mlfc_pkg::CT_DIFF, 19, 20, 0));
    send_word(make_cmd(mlfc_pkg::CT_DRIVE, 0, 5, 0));
    send_word(make_cmd(mlfc_pkg::CT_DRIVE, 10, 7, 0));
    send_word(make_cmd(mlfc_pkg::CT_DRIVE, 10, -3, 0));
    send_word(make_cmd(mlfc_pkg::CT_DRIVE, -256, 1, 0));
    send_word(make_cmd(mlfc_pkg::CT_DRIVE, -5, 0, 0));
    send_word(make_cmd(mlfc_pkg::CT_SINGLE, 255, 0, 4'd0));
    send_word(make_cmd(mlfc_pkg::CT_SINGLE, -256, 0, 4'd15));
    send_word(make_cmd(mlfc_pkg::CT_SINGLE, 0, 0, 4'd7));
    // reserved type leaves the frame alone and emits nothing
    send_word(make_cmd(mlfc_pkg::CT_RSVD, 1, 1, 0));
  endtask

  // Bad address, bad start, then a clean frame with a command slipped in
  task automatic test_parser_recovery();
    send_link_byte(mlfc_pkg::START_BYTE);
    send_link_byte(mlfc_pkg::START_BYTE);   // bad address, not taken as a new start
    send_link_byte(mlfc_pkg::ADDR_BYTE);
    send_link_byte(8'h07);
    // both sides negative and above setpoint: all speeds negated
    send_frame(FLAW_NONE, 1'b1, 10, make_cmd(mlfc_pkg::CT_DIFF, -200, -100, 0));
  endtask

  // Wrong stop byte at the end of a full frame
  task automatic test_end_check();
    send_frame(FLAW_STOP, 1'b0, -1, random_cmd());
  endtask

  // Long output hold-off while commands keep coming
  task automatic test_output_backpressure();
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      send_word(make_cmd(2'($urandom_range(2)), rand_speed(), rand_speed(),
                         4'($urandom_range(15))));
  endtask

  // Mostly well-formed frames and commands, some damaged frames and noise
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
    int          start_cnt;
    int          pick;
    frame_flaw_t flaw;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    start_cnt     = n_words;
    while (n_words - start_cnt < n_items) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_word(random_cmd());
      end else if (pick < 70) begin
        send_frame(FLAW_NONE, 1'b0,
                   ($urandom_range(99) < 15) ? int'($urandom_range(FRAME_BYTES - 1)) : -1,
                   random_cmd());
      end else begin
        flaw = frame_flaw_t'($urandom_range(FLAW_SHORT, FLAW_START));
        send_frame(flaw, 1'b0, -1, random_cmd());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_frame     = mlfc_pkg::FRAME_RESET;
    parse_ph      = mlfc_pkg::PH_HUNT;
    info_cnt      = 0;
    len_seen      = '0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 0;
    cycle_cnt     = 0;
    fail_cnt      = 0;
    n_words       = 0;
    n_results     = 0;
    n_frame_runs  = 0;
    n_tlm_runs    = 0;
    n_err_runs    = 0;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_kind         <= mlfc_pkg::KIND_CMD;
    in_control_type <= mlfc_pkg::CT_DIFF;
    in_left_speed   <= '0;
    in_right_speed  <= '0;
    in_drive_speed  <= '0;
    in_steer_angle  <= '0;
    in_motor_select <= '0;
    in_motor_drive  <= '0;
    in_rx_byte      <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_command_frames();
    test_parser_recovery();
    test_end_check();
    test_output_backpressure();
    test_random_traffic(0, 0, 25);
    test_random_traffic(54, 0, 25);
    test_random_traffic(0, 54, 25);
    test_random_traffic(29, 29, 25);

    // drain
    in_valid      <= 1'b0;
    rcv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d words: commands of all control types, clean, damaged and noisy frames,",
             n_words);
    $display("four idle mixes and a long output hold; %0d results (%0d cmd, %0d tlm, %0d err)",
             n_results, n_frame_runs, n_tlm_runs, n_err_runs);
    if (fail_cnt == 0) begin
      $display("tb_motor_link_frame_codec_top OK");
    end else begin
      $display("tb_motor_link_frame_codec_top NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mlfc_pkg.sv
rtl/core/mlfc_ctrl.sv
rtl/core/mlfc_dp.sv
rtl/core/motor_link_frame_codec_top.sv
bench/tb_motor_link_frame_codec_top.sv
